/* design/assert_macros.svh */
// assertion macros for the hash cache
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLIES(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, pre, post)
`define ASSERT_NEXT(label, clk, rst_n, pre, post)
`endif
`endif

/* design/lphc_pkg.sv */
package lphc_pkg;
    localparam int unsigned TableSize = 1024;
    localparam int unsigned SlotBits = $clog2(TableSize);
    localparam int unsigned QueueDepth = 2;

    localparam logic MODE_LOOKUP = 1'b0;
    localparam logic MODE_INSERT = 1'b1;

    localparam logic CFG_SEED = 1'b0;
    localparam logic CFG_LIMIT = 1'b1;

    typedef struct packed {
        logic        mode;
        logic [63:0] key;
        logic [63:0] value;
        logic [31:0] hash;
    } lphc_job_t;
endpackage

/* design/linear_probe_hash_cache.sv */
// linear-probing key/value cache. start with busy low takes one beat (mode, key, value);
// the front holds busy while it hashes and while the two-entry queue to the back is full,
// so a new beat is taken only once the last one has gone into the queue. the back reads
// one slot per probe from the table ram (S_READ, then S_CHECK), up to limit+1 probes per
// item. a lookup yields one result beat on done for exactly one cycle; the receiver
// cannot stall it. inserts yield nothing. after reset the back clears the valid bits of
// all 1024 slots before probing. configuration writes are always taken;
// write only while no item is in flight.
`include "assert_macros.svh"
module linear_probe_hash_cache import lphc_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        mode,
    input  logic [63:0] key,
    input  logic [63:0] value,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [0:0]  cfg_index,
    input  logic [31:0] cfg_data,
    output logic        done,
    output logic        hit,
    output logic [63:0] found_value
);
    logic [31:0] seed_reg;
    logic [9:0]  limit_reg;
    logic        q_full, q_push, q_pop, q_empty, back_idle;
    lphc_job_t   q_in, q_out;

    assign cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg <= '0;
            limit_reg <= 10'd8;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_SEED:  seed_reg <= cfg_data;
                CFG_LIMIT: limit_reg <= cfg_data[9:0];
                default:   ;
            endcase
        end
    end

    lphc_front u_front (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .mode(mode),
        .key(key), .value(value), .seed(seed_reg), .q_full(q_full),
        .q_push(q_push), .q_data(q_in)
    );
    lphc_queue u_queue (
        .clk(clk), .rst_n(rst_n), .push(q_push), .push_data(q_in), .full(q_full),
        .pop(q_pop), .empty(q_empty), .pop_data(q_out)
    );
    lphc_back u_back (
        .clk(clk), .rst_n(rst_n), .q_empty(q_empty), .q_data(q_out), .q_pop(q_pop),
        .limit(limit_reg), .idle(back_idle), .done(done), .hit(hit),
        .found_value(found_value)
    );

    `ASSERT_IMPLIES(a_no_push_full, clk, rst_n, q_full, !q_push)
    `ASSERT_IMPLIES(a_no_pop_empty, clk, rst_n, q_empty, !q_pop)
    `ASSERT_IMPLIES(a_miss_zero, clk, rst_n, done && !hit, found_value == 64'd0)
    `ASSERT_NEXT(a_done_pulse, clk, rst_n, done, !done)
    `ASSERT_IMPLIES(a_idle_quiet, clk, rst_n, back_idle, !done || !q_pop)
endmodule

/* design/lphc_ram.sv */
module lphc_ram #(
    parameter int unsigned Width = 8,
    parameter int unsigned Depth = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(Depth)-1:0] waddr,
    input  logic [Width-1:0]         wdata,
    input  logic [$clog2(Depth)-1:0] raddr,
    output logic [Width-1:0]         rdata
);
    logic [Width-1:0] mem [Depth];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

/* design/lphc_front.sv */
module lphc_front import lphc_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        mode,
    input  logic [63:0] key,
    input  logic [63:0] value,
    input  logic [31:0] seed,
    input  logic        q_full,
    output logic        q_push,
    output lphc_job_t   q_data
);
    // hash sequenced by a step counter, at most one multiply per step
    logic        act_reg, act_next;
    logic [3:0]  step_reg, step_next;
    logic [31:0] h_reg, h_next;
    logic [31:0] k_reg, k_next;
    logic        mode_reg;
    logic [63:0] key_reg, val_reg;

    function automatic logic [31:0] rotl(input logic [31:0] x, input int r);
        rotl = (x << r) | (x >> (32 - r));
    endfunction

    assign busy = act_reg;
    assign q_push = act_reg && (step_reg == 4'd11) && !q_full;
    assign q_data = '{mode: mode_reg, key: key_reg, value: val_reg, hash: h_reg};

    always_comb
    begin
        act_next = act_reg;
        step_next = step_reg;
        h_next = h_reg;
        k_next = k_reg;
        if (!act_reg)
        begin
            if (start)
            begin
                act_next = 1'b1;
                step_next = 4'd0;
                h_next = seed;
                k_next = key[31:0];
            end
        end
        else
        begin
            unique case (step_reg)
                4'd0, 4'd4: k_next = k_reg * 32'hCC9E2D51;
                4'd1, 4'd5: k_next = rotl(k_reg, 15) * 32'h1B873593;
                4'd2, 4'd6: h_next = rotl(h_reg ^ k_reg, 13);
                4'd3, 4'd7:
                begin
                    h_next = h_reg * 32'd5 + 32'hE6546B64;
                    k_next = key_reg[63:32];
                end
                4'd8:
                begin
                    h_next = (h_reg ^ 32'd8) ^ ((h_reg ^ 32'd8) >> 16);
                    h_next = h_next * 32'h85EBCA6B;
                end
                4'd9:
                begin
                    h_next = (h_reg ^ (h_reg >> 13)) * 32'hC2B2AE35;
                end
                4'd10: h_next = h_reg ^ (h_reg >> 16);
                default:
                begin
                    if (!q_full)
                    begin
                        act_next = 1'b0;
                    end
                end
            endcase
            if (step_reg != 4'd11)
            begin
                step_next = step_reg + 4'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            act_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            act_reg <= act_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        h_reg <= h_next;
        k_reg <= k_next;
        if (!act_reg && start)
        begin
            mode_reg <= mode;
            key_reg <= key;
            val_reg <= value;
        end
    end
endmodule

/* design/lphc_queue.sv */
module lphc_queue import lphc_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  lphc_job_t push_data,
    output logic      full,
    input  logic      pop,
    output logic      empty,
    output lphc_job_t pop_data
);
    localparam int unsigned PtrBits = $clog2(QueueDepth);
    lphc_job_t          buf_reg [QueueDepth];
    logic [PtrBits-1:0] wr_reg, rd_reg;
    logic [PtrBits:0]   cnt_reg;

    assign full = (cnt_reg == (PtrBits+1)'(QueueDepth));
    assign empty = (cnt_reg == '0);
    assign pop_data = buf_reg[rd_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg <= '0;
            rd_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_reg <= wr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_reg <= rd_reg + 1'b1;
            end
            cnt_reg <= cnt_reg + (PtrBits+1)'(push) - (PtrBits+1)'(pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            buf_reg[wr_reg] <= push_data;
        end
    end
endmodule

/* design/lphc_back.sv */
module lphc_back import lphc_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        q_empty,
    input  lphc_job_t   q_data,
    output logic        q_pop,
    input  logic [9:0]  limit,
    output logic        idle,
    output logic        done,
    output logic        hit,
    output logic [63:0] found_value
);
    typedef enum logic [2:0] {S_IDLE, S_CLEAR, S_READ, S_CHECK, S_RESULT} state_t;
    state_t             state_reg;
    logic [SlotBits-1:0] clr_reg;
    logic [9:0]         cnt_reg;
    logic [31:0]        pos_reg;
    lphc_job_t          job_reg;
    logic               valid_q, we;
    logic [SlotBits-1:0] waddr;
    logic [127:0]       wdata, rdata;
    logic               vwe, vwd;
    logic [SlotBits-1:0] pos;

    assign pos = pos_reg[SlotBits-1:0];
    assign idle = (state_reg == S_IDLE) && q_empty;
    assign q_pop = (state_reg == S_IDLE) && !q_empty;

    // valid bits live in a ram too, cleared by a sweep after reset
    lphc_ram #(.Width(1), .Depth(TableSize)) u_valid (
        .clk(clk), .we(vwe), .waddr(waddr), .wdata(vwd), .raddr(pos), .rdata(valid_q)
    );
    lphc_ram #(.Width(128), .Depth(TableSize)) u_data (
        .clk(clk), .we(we), .waddr(pos), .wdata(wdata), .raddr(pos), .rdata(rdata)
    );

    logic last, match;
    assign last = (cnt_reg == limit);
    assign match = valid_q && (rdata[127:64] == job_reg.key);
    assign we = (state_reg == S_CHECK) && (job_reg.mode == MODE_INSERT) && (!valid_q || last);
    assign wdata = {job_reg.key, job_reg.value};
    assign vwe = we || (state_reg == S_CLEAR);
    assign vwd = (state_reg != S_CLEAR);
    assign waddr = (state_reg == S_CLEAR) ? clr_reg : pos;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            clr_reg <= '0;
            done <= 1'b0;
            hit <= 1'b0;
            found_value <= '0;
        end
        else
        begin
            done <= 1'b0;
            unique case (state_reg)
                S_CLEAR:
                begin
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == SlotBits'(TableSize - 1))
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (!q_empty)
                    begin
                        job_reg <= q_data;
                        pos_reg <= q_data.hash;
                        cnt_reg <= '0;
                        state_reg <= S_READ;
                    end
                end
                S_READ: state_reg <= S_CHECK;
                S_CHECK:
                begin
                    if (job_reg.mode == MODE_INSERT)
                    begin
                        if (!valid_q || last)
                        begin
                            state_reg <= S_IDLE;
                        end
                        else
                        begin
                            cnt_reg <= cnt_reg + 1'b1;
                            pos_reg <= pos_reg + 32'd1;
                            state_reg <= S_READ;
                        end
                    end
                    else if (match || last)
                    begin
                        done <= 1'b1;
                        hit <= match;
                        found_value <= match ? rdata[63:0] : '0;
                        state_reg <= S_IDLE;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + 1'b1;
                        pos_reg <= pos_reg + 32'd1;
                        state_reg <= S_READ;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule
